// ----- src/unordered_pair_set_table_assert.svh -----
// assertion macros used by the checker file
`ifndef UNORDERED_PAIR_SET_TABLE_ASSERT_SVH
`define UNORDERED_PAIR_SET_TABLE_ASSERT_SVH

// same-cycle implication, reset masked
`define UPST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("upst check failed");

// next-cycle implication, reset masked
`define UPST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("upst check failed");

`endif

// ----- src/upst_pkg.sv -----
// types and codes shared by the pair set table modules
`default_nettype none
package upst_pkg;

  localparam int HANDLE_W = 32;
  localparam int COUNT_W  = 7;

  // request codes
  localparam logic [2:0] REQ_ADD     = 3'd0;
  localparam logic [2:0] REQ_REMOVE  = 3'd1;
  localparam logic [2:0] REQ_PAIR_Q  = 3'd2;
  localparam logic [2:0] REQ_REM_ALL = 3'd3;
  localparam logic [2:0] REQ_OBJ_Q   = 3'd4;
  localparam logic [2:0] REQ_LIST    = 3'd5;

  typedef struct packed {
    logic [2:0]          req_type;
    logic [HANDLE_W-1:0] obj_a;
    logic [HANDLE_W-1:0] obj_b;
    logic [COUNT_W-1:0]  max_count;
  } in_t;

  typedef struct packed {
    logic                found;
    logic [COUNT_W-1:0]  pair_count;
    logic [HANDLE_W-1:0] partner;
    logic                partner_valid;
    logic                table_full;
    logic                last;
  } out_t;

  // classified request passed from front to back
  typedef struct packed {
    logic [2:0]          op;
    logic [HANDLE_W-1:0] a;
    logic [HANDLE_W-1:0] b;
    logic [COUNT_W-1:0]  maxc;
  } req_t;

endpackage
`default_nettype wire

// ----- src/unordered_pair_set_table.sv -----
// top level of the unordered pair set table
//
//   channel   ports                      handshake
//   request   push, full, in_data        accepted on push && !full
//   result    empty, pop, out_data       accepted on pop && !empty
//
// each table entry scanned takes a ram read step and a compare step, and each entry
// moved by a remove takes a read of the top entry and a copy into the freed slot; the
// single read port of the handle rams sets this. reset is synchronous and empties the
// table at once. two-entry queues on both sides let requests and results wait
// independently; a list stalls in its compare step while a partner is pending and the
// result queue is full.
`default_nettype none
module unordered_pair_set_table #(
  parameter int CAPACITY    = 64,
  parameter int HANDLE_BITS = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  output logic                full,
  input  wire upst_pkg::in_t  in_data,
  output logic                empty,
  input  wire logic           pop,
  output upst_pkg::out_t      out_data
);
  import upst_pkg::*;

  req_t req;
  logic req_empty, req_pop;
  out_t res;
  logic res_push, res_full;
  logic [$bits(out_t)-1:0] q_rdata;

  upst_front #(.CAPACITY(CAPACITY), .HANDLE_BITS(HANDLE_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_data   (in_data),
    .full      (full),
    .req_pop   (req_pop),
    .req       (req),
    .req_empty (req_empty)
  );

  upst_back #(.CAPACITY(CAPACITY), .HANDLE_BITS(HANDLE_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .req_empty (req_empty),
    .req_pop   (req_pop),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  // result queue
  upst_fifo #(.WIDTH($bits(out_t))) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (q_rdata),
    .empty (empty)
  );

  assign out_data = out_t'(q_rdata);
endmodule
`default_nettype wire

// ----- src/upst_ram.sv -----
// generic single-write, single-read ram with registered read
`default_nettype none
module upst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- src/upst_fifo.sv -----
// two-entry queue used between front, back and result port
`default_nettype none
module upst_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);
  logic [WIDTH-1:0] slot_r [2];
  logic             wptr_r, wptr_nxt;
  logic             rptr_r, rptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rdata   = slot_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // pointer and count update
  always_comb begin
    wptr_nxt = do_push ? ~wptr_r : wptr_r;
    rptr_nxt = do_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= wdata;
    end
  end
endmodule
`default_nettype wire

// ----- src/upst_front.sv -----
// front end: takes requests, masks handles, clamps counts, queues them
`default_nettype none
module upst_front #(
  parameter int CAPACITY    = 64,
  parameter int HANDLE_BITS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire upst_pkg::in_t in_data,
  output logic               full,
  input  wire logic          req_pop,
  output upst_pkg::req_t     req,
  output logic               req_empty
);
  import upst_pkg::*;

  localparam logic [HANDLE_W-1:0] HMASK =
    (HANDLE_BITS >= HANDLE_W) ? {HANDLE_W{1'b1}} :
    HANDLE_W'((64'd1 << HANDLE_BITS) - 64'd1);
  localparam logic [COUNT_W-1:0] CAP_C = COUNT_W'(CAPACITY);

  req_t cls;
  logic [$bits(req_t)-1:0] q_rdata;

  // classify the incoming request
  always_comb begin
    cls.op   = in_data.req_type;
    cls.a    = in_data.obj_a & HMASK;
    cls.b    = in_data.obj_b & HMASK;
    cls.maxc = (in_data.max_count > CAP_C) ? CAP_C : in_data.max_count;
  end

  upst_fifo #(.WIDTH($bits(req_t))) u_req_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (cls),
    .full  (full),
    .pop   (req_pop),
    .rdata (q_rdata),
    .empty (req_empty)
  );

  assign req = req_t'(q_rdata);
endmodule
`default_nettype wire

// ----- src/upst_back.sv -----
// back end: scans the table through the rams and produces results
`default_nettype none
module upst_back #(
  parameter int CAPACITY    = 64,
  parameter int HANDLE_BITS = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire upst_pkg::req_t req,
  input  wire logic           req_empty,
  output logic                req_pop,
  output logic                res_push,
  output upst_pkg::out_t      res,
  input  wire logic           res_full
);
  import upst_pkg::*;

  localparam int SW = (HANDLE_BITS >= HANDLE_W) ? HANDLE_W : HANDLE_BITS;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_F = CW'(CAPACITY);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_RD     = 6'b000010,
    S_CMP    = 6'b000100,
    S_TOP_RD = 6'b001000,
    S_TOP_CP = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic [2:0]         op_r, op_nxt;
  logic [SW-1:0]      a_r, a_nxt, b_r, b_nxt;
  logic [COUNT_W-1:0] maxc_r, maxc_nxt;
  logic [AW-1:0]      idx_r, idx_nxt, pos_r, pos_nxt;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic [COUNT_W-1:0] n_r, n_nxt;
  logic               hit_r, hit_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [SW-1:0]      pend_r, pend_nxt;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [SW-1:0]      wd_first, wd_second, rd_first, rd_second;

  logic               pair_hit, holds_a, at_end, list_hit;
  logic [SW-1:0]      list_partner;
  logic [AW-1:0]      top_idx;

  assign top_idx = AW'(fill_r - CW'(1));
  assign at_end  = ((CW'(idx_r) + CW'(1)) == fill_r);

  // entry compare
  always_comb begin
    pair_hit = ((rd_first == a_r) && (rd_second == b_r)) ||
               ((rd_first == b_r) && (rd_second == a_r));
    holds_a  = (rd_first == a_r) || (rd_second == a_r);
    list_hit = holds_a;
    list_partner = (rd_first == a_r) ? rd_second : rd_first;
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    maxc_nxt   = maxc_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    fill_nxt   = fill_r;
    n_nxt      = n_r;
    hit_nxt    = hit_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    req_pop    = 1'b0;
    res_push   = 1'b0;
    res        = '0;
    we         = 1'b0;
    waddr      = pos_r;
    wd_first   = rd_first;
    wd_second  = rd_second;
    raddr      = idx_r;

    case (state_r)
      S_IDLE: begin
        if (!req_empty) begin
          req_pop    = 1'b1;
          op_nxt     = req.op;
          a_nxt      = req.a[SW-1:0];
          b_nxt      = req.b[SW-1:0];
          maxc_nxt   = req.maxc;
          n_nxt      = '0;
          hit_nxt    = 1'b0;
          pend_v_nxt = 1'b0;
          idx_nxt    = '0;
          state_nxt  = S_DONE;
          case (req.op)
            REQ_ADD, REQ_REMOVE, REQ_PAIR_Q, REQ_OBJ_Q: begin
              if (fill_r != '0) state_nxt = S_RD;
            end
            REQ_REM_ALL: begin
              idx_nxt = top_idx;
              if (fill_r != '0) state_nxt = S_RD;
            end
            REQ_LIST: begin
              if (fill_r != '0 && req.maxc != '0) state_nxt = S_RD;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_RD: begin
        state_nxt = S_CMP;
      end

      S_CMP: begin
        case (op_r)
          REQ_ADD, REQ_REMOVE, REQ_PAIR_Q: begin
            if (pair_hit) begin
              hit_nxt   = 1'b1;
              pos_nxt   = idx_r;
              state_nxt = (op_r == REQ_REMOVE) ? S_TOP_RD : S_DONE;
            end else if (at_end) begin
              state_nxt = S_DONE;
            end else begin
              idx_nxt   = idx_r + AW'(1);
              state_nxt = S_RD;
            end
          end
          REQ_OBJ_Q: begin
            if (holds_a) n_nxt = n_r + COUNT_W'(1);
            if (at_end) begin
              state_nxt = S_DONE;
            end else begin
              idx_nxt   = idx_r + AW'(1);
              state_nxt = S_RD;
            end
          end
          REQ_REM_ALL: begin
            if (holds_a) begin
              n_nxt     = n_r + COUNT_W'(1);
              pos_nxt   = idx_r;
              state_nxt = S_TOP_RD;
            end else if (idx_r == '0) begin
              state_nxt = S_DONE;
            end else begin
              idx_nxt   = idx_r - AW'(1);
              state_nxt = S_RD;
            end
          end
          REQ_LIST: begin
            if (!list_hit) begin
              if (at_end) begin
                state_nxt = S_DONE;
              end else begin
                idx_nxt   = idx_r + AW'(1);
                state_nxt = S_RD;
              end
            end else if (!(pend_v_r && res_full)) begin
              // send the previous partner, hold the new one back
              if (pend_v_r) begin
                res_push          = 1'b1;
                res.found         = 1'b1;
                res.pair_count    = n_r;
                res.partner       = HANDLE_W'(pend_r);
                res.partner_valid = 1'b1;
              end
              pend_v_nxt = 1'b1;
              pend_nxt   = list_partner;
              n_nxt      = n_r + COUNT_W'(1);
              if ((n_r + COUNT_W'(1)) == maxc_r || at_end) begin
                state_nxt = S_DONE;
              end else begin
                idx_nxt   = idx_r + AW'(1);
                state_nxt = S_RD;
              end
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end

      S_TOP_RD: begin
        raddr     = top_idx;
        state_nxt = S_TOP_CP;
      end

      // move the last entry into the freed slot
      S_TOP_CP: begin
        raddr    = top_idx;
        we       = 1'b1;
        waddr    = pos_r;
        fill_nxt = fill_r - CW'(1);
        if (op_r == REQ_REM_ALL && idx_r != '0) begin
          idx_nxt   = idx_r - AW'(1);
          state_nxt = S_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!res_full) begin
          res_push   = 1'b1;
          res.last   = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
          case (op_r)
            REQ_ADD: begin
              res.found      = hit_r;
              res.table_full = !hit_r && (fill_r == CAP_F);
              if (!hit_r && fill_r != CAP_F) begin
                we        = 1'b1;
                waddr     = AW'(fill_r);
                wd_first  = a_r;
                wd_second = b_r;
                fill_nxt  = fill_r + CW'(1);
              end
            end
            REQ_REMOVE, REQ_PAIR_Q: begin
              res.found = hit_r;
            end
            REQ_REM_ALL, REQ_OBJ_Q: begin
              res.found      = (n_r != '0);
              res.pair_count = n_r;
            end
            REQ_LIST: begin
              if (pend_v_r) begin
                res.found         = 1'b1;
                res.pair_count    = n_r;
                res.partner       = HANDLE_W'(pend_r);
                res.partner_valid = 1'b1;
              end
            end
            default: res.last = 1'b1;
          endcase
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fill_r   <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    maxc_r <= maxc_nxt;
    idx_r  <= idx_nxt;
    pos_r  <= pos_nxt;
    n_r    <= n_nxt;
    hit_r  <= hit_nxt;
    pend_r <= pend_nxt;
  end

  upst_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_first_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wd_first),
    .raddr (raddr),
    .rdata (rd_first)
  );

  upst_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_second_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wd_second),
    .raddr (raddr),
    .rdata (rd_second)
  );
endmodule
`default_nettype wire

// ----- src/upst_checker.sv -----
// port-level checks for the pair set table, bound to the top level
`default_nettype none
`include "unordered_pair_set_table_assert.svh"
module upst_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           push,
  input wire logic           full,
  input wire upst_pkg::in_t  in_data,
  input wire logic           empty,
  input wire logic           pop,
  input wire upst_pkg::out_t out_data
);
  import upst_pkg::*;

  // an accepted request carries known fields
  `UPST_ASSERT_NOW(a_in_known, (push && !full), (!$isunknown(in_data)))
  // a waiting result holds until taken
  `UPST_ASSERT_NEXT(a_res_hold, (!empty && !pop), (!empty && $stable(out_data)))
  // a listed partner always comes with found and a nonzero count
  `UPST_ASSERT_NOW(a_partner_cnt, (!empty && out_data.partner_valid),
                   (out_data.found && out_data.pair_count != '0))
  // a dropped add is a single final result of an absent pair
  `UPST_ASSERT_NOW(a_full_last, (!empty && out_data.table_full),
                   (out_data.last && !out_data.found && !out_data.partner_valid))
  // only listed partners come without the last mark
  `UPST_ASSERT_NOW(a_nolist_zero, (!empty && !out_data.last), (out_data.partner_valid))
endmodule

bind unordered_pair_set_table upst_checker u_upst_checker (.*);
`default_nettype wire
